// ----- src/mgrad_pkg.sv -----
// shared constants, types and the window gradient function of the gradient block
package mgrad_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_ROWS   = 4096;
	localparam int PIX_W      = 8;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_RES    = 4;
	localparam int RES_CNT_W  = 3;
	localparam int OQ_DEPTH   = 8;
	localparam int OQ_AW      = 3;
	localparam int OQ_CNT_W   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

	localparam logic [ROW_W-1:0] RST_LAST_ROW = 12'd479;
	localparam logic [COL_W-1:0] RST_LAST_COL = 10'd639;

	typedef struct packed {
		logic [ROW_W-1:0] last_row;
		logic [COL_W-1:0] last_col;
		logic             restart;
	} mgrad_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] grad;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
		logic             eof;
	} res_word_t;

	typedef struct packed {
		logic [MAX_RES-1:0]            vld;
		res_word_t [MAX_RES-1:0]       w;
	} res_bundle_t;

	// max minus min over the window cells picked by the column and row masks
	function automatic logic [PIX_W-1:0] grad3x3(
		input logic [8:0][PIX_W-1:0] win,
		input logic [2:0]            col_m,
		input logic [2:0]            row_m
	);
		logic [2:0][PIX_W-1:0] rlo;
		logic [2:0][PIX_W-1:0] rhi;
		logic [PIX_W-1:0]      lo;
		logic [PIX_W-1:0]      hi;
		logic                  any;
		lo  = '1;
		hi  = '0;
		any = 1'b0;
		for (int k = 0; k < 3; k++) begin
			rlo[k] = '1;
			rhi[k] = '0;
			for (int j = 0; j < 3; j++) begin
				if (col_m[j]) begin
					if (win[k*3+j] < rlo[k]) rlo[k] = win[k*3+j];
					if (win[k*3+j] > rhi[k]) rhi[k] = win[k*3+j];
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (row_m[k] && (col_m != 3'b000)) begin
				any = 1'b1;
				if (rlo[k] < lo) lo = rlo[k];
				if (rhi[k] > hi) hi = rhi[k];
			end
		end
		return any ? (hi - lo) : '0;
	endfunction

endpackage

// ----- src/morph_gradient_3x3.sv -----
// top level of the 3x3 morphological gradient with its configuration registers
// Pixels enter in raster order at up to one word per clock while the queue has
// room; each result word is the max minus min of the clipped 3x3 neighbourhood.
// Results of row r come while row r+1 enters, once the pixel that completes
// them has passed stages s1 and s2, and leave through an eight-word queue at
// up to one word per clock. On the final row each pixel yields two words, so
// the output port sets the rate there and holds input back. Both row stores sit in
// one 1024 x 16 ram, read and written once per pixel at its column; a one-column
// frame hits the same entry on back-to-back pixels and is served by forwarding.
// A write to frame_rows or frame_cols restarts the frame at row 0, column 0.
module morph_gradient_3x3 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mgrad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mgrad_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mgrad_pkg::PIX_W-1:0]      pixel,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mgrad_pkg::PIX_W-1:0]      grad_value,
	output logic [mgrad_pkg::ROW_W-1:0]      out_row,
	output logic [mgrad_pkg::COL_W-1:0]      out_col,
	output logic                             last_in_run,
	output logic                             end_of_frame
);

	localparam int RW = mgrad_pkg::ROW_W;
	localparam int CW = mgrad_pkg::COL_W;
	localparam int DW = mgrad_pkg::CFG_DATA_W;

	logic                   cfg_wr;
	logic [RW-1:0]          last_row_q;
	logic [CW-1:0]          last_col_q;
	logic                   restart;
	logic [CW:0]            col_data;
	mgrad_pkg::mgrad_cfg_t  cfg;
	logic                   space_ok;
	logic                   push;
	mgrad_pkg::res_bundle_t bundle;
	mgrad_pkg::res_word_t   head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign col_data  = cfg_data[CW:0];
	assign restart   = cfg_wr &&
		(cfg_index inside {mgrad_pkg::REG_FRAME_ROWS, mgrad_pkg::REG_FRAME_COLS});

	// store count minus one, clamped to the valid range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= mgrad_pkg::RST_LAST_ROW;
			last_col_q <= mgrad_pkg::RST_LAST_COL;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					mgrad_pkg::REG_FRAME_ROWS: begin
						if (cfg_data == '0)
							last_row_q <= '0;
						else if (cfg_data > DW'(mgrad_pkg::MAX_ROWS))
							last_row_q <= '1;
						else
							last_row_q <= RW'(cfg_data - DW'(1));
					end
					mgrad_pkg::REG_FRAME_COLS: begin
						if (col_data == '0)
							last_col_q <= '0;
						else if (col_data > (CW+1)'(mgrad_pkg::MAX_COLS))
							last_col_q <= '1;
						else
							last_col_q <= CW'(col_data - (CW+1)'(1));
					end
					default: ;
				endcase
			end
		end
	end

	assign cfg.last_row = last_row_q;
	assign cfg.last_col = last_col_q;
	assign cfg.restart  = restart;

	mgrad_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel   (pixel),
		.space_ok(space_ok),
		.push    (push),
		.bundle  (bundle)
	);

	mgrad_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.bundle   (bundle),
		.space_ok (space_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign grad_value   = head.grad;
	assign out_row      = head.row;
	assign out_col      = head.col;
	assign last_in_run  = head.last;
	assign end_of_frame = head.eof;

endmodule

// ----- src/mgrad_ram.sv -----
// generic single-port-write, registered-read ram
module mgrad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ----- src/mgrad_core.sv -----
// position counters, row store read-modify-write, window and gradient stages
module mgrad_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mgrad_pkg::mgrad_cfg_t       cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mgrad_pkg::PIX_W-1:0] pixel,
	input  logic                        space_ok,
	output logic                        push,
	output mgrad_pkg::res_bundle_t      bundle
);

	localparam int PW = mgrad_pkg::PIX_W;
	localparam int CW = mgrad_pkg::COL_W;
	localparam int RW = mgrad_pkg::ROW_W;

	logic          en;
	logic          acc;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          wrap;
	logic [RW-1:0] i_cur;
	logic [CW-1:0] c_cur;
	logic          lc_cur;
	logic          fr_cur;

	logic          v_s1;
	logic [PW-1:0] pix_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;
	logic          lc_s1;
	logic          fr_s1;
	logic          fwd_s1;
	logic [PW-1:0] fold_s1;
	logic [PW-1:0] fnew_s1;

	logic [2*PW-1:0] rd_data;
	logic [PW-1:0]   old_eff;
	logic [PW-1:0]   new_eff;

	logic [8:0][PW-1:0] win_q;

	logic          v_s2;
	logic [RW-1:0] row_s2;
	logic [CW-1:0] col_s2;
	logic          lc_s2;
	logic          fr_s2;

	logic [2:0] rows_up;
	logic [2:0] rows_fin;
	logic [2:0] cols_ctr;
	logic [2:0] cols_rgt;
	logic [mgrad_pkg::MAX_RES-1:0] vld;
	mgrad_pkg::res_word_t [mgrad_pkg::MAX_RES-1:0] w;

	assign en       = space_ok;
	assign in_ready = en;
	assign acc      = in_valid && in_ready;

	assign wrap   = (col_q > cfg.last_col) || (row_q > cfg.last_row);
	assign c_cur  = wrap ? '0 : col_q;
	assign i_cur  = wrap ? '0 : row_q;
	assign lc_cur = (c_cur == cfg.last_col);
	assign fr_cur = (i_cur == cfg.last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg.restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (lc_cur) begin
				col_q <= '0;
				row_q <= fr_cur ? '0 : i_cur + RW'(1);
			end else begin
				col_q <= c_cur + CW'(1);
				row_q <= i_cur;
			end
		end
	end

	// older store in the upper half, newer store in the lower half
	mgrad_ram #(
		.WIDTH(2*PW),
		.DEPTH(mgrad_pkg::MAX_COLS)
	) u_rows (
		.clk  (clk),
		.we   (en && v_s1),
		.waddr(col_s1),
		.wdata({new_eff, pix_s1}),
		.re   (acc),
		.raddr(c_cur),
		.rdata(rd_data)
	);

	assign old_eff = fwd_s1 ? fold_s1 : rd_data[2*PW-1:PW];
	assign new_eff = fwd_s1 ? fnew_s1 : rd_data[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= pixel;
			row_s1  <= i_cur;
			col_s1  <= c_cur;
			lc_s1   <= lc_cur;
			fr_s1   <= fr_cur;
			// same column written this edge: take it from the stage, not the ram
			fwd_s1  <= v_s1 && (c_cur == col_s1);
			fold_s1 <= new_eff;
			fnew_s1 <= pix_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			lc_s2   <= lc_s1;
			fr_s2   <= fr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (en && v_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[2] <= old_eff;
			win_q[5] <= new_eff;
			win_q[8] <= pix_s1;
		end
	end

	// masks: bit 0 top row / left column
	assign rows_up  = {1'b1, 1'b1, (row_s2 > RW'(1))};
	assign rows_fin = {1'b1, (row_s2 != '0), 1'b0};
	assign cols_ctr = {1'b1, 1'b1, (col_s2 > CW'(1))};
	assign cols_rgt = {1'b1, (col_s2 != '0), 1'b0};

	always_comb begin
		vld[0] = (row_s2 != '0) && (col_s2 != '0);
		vld[1] = (row_s2 != '0) && lc_s2;
		vld[2] = fr_s2 && (col_s2 != '0);
		vld[3] = fr_s2 && lc_s2;

		w[0].grad = mgrad_pkg::grad3x3(win_q, cols_ctr, rows_up);
		w[0].row  = row_s2 - RW'(1);
		w[0].col  = col_s2 - CW'(1);
		w[0].eof  = 1'b0;

		w[1].grad = mgrad_pkg::grad3x3(win_q, cols_rgt, rows_up);
		w[1].row  = row_s2 - RW'(1);
		w[1].col  = col_s2;
		w[1].eof  = 1'b0;

		w[2].grad = mgrad_pkg::grad3x3(win_q, cols_ctr, rows_fin);
		w[2].row  = row_s2;
		w[2].col  = col_s2 - CW'(1);
		w[2].eof  = 1'b0;

		w[3].grad = mgrad_pkg::grad3x3(win_q, cols_rgt, rows_fin);
		w[3].row  = row_s2;
		w[3].col  = col_s2;
		w[3].eof  = 1'b1;

		w[3].last = vld[3];
		w[2].last = vld[2] && !vld[3];
		w[1].last = vld[1] && !vld[2] && !vld[3];
		w[0].last = vld[0] && !vld[1] && !vld[2] && !vld[3];
	end

	assign push       = en && v_s2;
	assign bundle.vld = vld;
	assign bundle.w   = w;

	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en) |=> (v_s2 && $stable(row_s2) && $stable(col_s2)))
		else $error("stage two moved during a stall");

	a_one_last : assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0({w[3].last, w[2].last, w[1].last, w[0].last}))
		else $error("more than one word marked last");

endmodule

// ----- src/mgrad_outq.sv -----
// result queue: takes up to four words a push, hands out one per clock if ready
module mgrad_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mgrad_pkg::res_bundle_t bundle,
	output logic                   space_ok,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mgrad_pkg::res_word_t   head
);

	localparam int AW = mgrad_pkg::OQ_AW;
	localparam int NW = mgrad_pkg::OQ_CNT_W;
	localparam int RC = mgrad_pkg::RES_CNT_W;

	mgrad_pkg::res_word_t ent_q [mgrad_pkg::OQ_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic [AW-1:0] wa [mgrad_pkg::MAX_RES];
	logic [RC-1:0] npush;
	logic          pop;

	always_comb begin
		npush = '0;
		for (int k = 0; k < mgrad_pkg::MAX_RES; k++) begin
			wa[k] = wr_ptr_q + AW'(npush);
			if (bundle.vld[k]) npush = npush + RC'(1);
		end
	end

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign head      = ent_q[rd_ptr_q];
	assign space_ok  = (cnt_q <= NW'(mgrad_pkg::OQ_DEPTH - mgrad_pkg::MAX_RES));

	always_ff @(posedge clk) begin
		if (push) begin
			for (int k = 0; k < mgrad_pkg::MAX_RES; k++) begin
				if (bundle.vld[k]) ent_q[wa[k]] <= bundle.w[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(npush);
			if (pop) rd_ptr_q <= rd_ptr_q + AW'(1);
			cnt_q <= cnt_q + (push ? NW'(npush) : NW'(0)) - (pop ? NW'(1) : NW'(0));
		end
	end

	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(mgrad_pkg::OQ_DEPTH))
		else $error("result queue overfilled");

	a_empty_ptrs : assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers differ on an empty queue");

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the 3x3 morphological gradient block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW   = mgrad_pkg::PIX_W;
	localparam int RW   = mgrad_pkg::ROW_W;
	localparam int CW   = mgrad_pkg::COL_W;
	localparam int IW   = mgrad_pkg::CFG_IDX_W;
	localparam int DW   = mgrad_pkg::CFG_DATA_W;
	localparam int NCOL = mgrad_pkg::MAX_COLS;
	localparam int NROW = mgrad_pkg::MAX_ROWS;
	localparam int NRES = mgrad_pkg::MAX_RES;

	localparam int          SETTLE_CYCLES = 16;
	localparam int          HOLD_CYCLES   = 300;
	localparam int unsigned RUN_LIMIT     = 200000;
	localparam int          RAND_PIXELS   = 64;
	localparam int          TALL_ROWS     = 24;

	localparam logic [IW-1:0] REG_UNUSED = 2'd3;

	typedef enum logic {D_CFG, D_PIX} step_kind_t;
	typedef enum int {RX_OPEN, RX_SPARSE, RX_COIN, RX_DENSE} rx_mode_t;
	typedef enum int {PX_ANY, PX_FLAT, PX_BINARY} px_style_t;

	typedef struct packed {
		step_kind_t    kind;
		logic [IW-1:0] idx;
		logic [DW-1:0] val;
		logic          typed;
		logic [PW-1:0] tgrad;
	} dir_step_t;

	localparam int N_DIR = 25;
	localparam dir_step_t DIRECTED [N_DIR] = '{
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'h000, 1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'h0ff, 1'b0, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_ROWS, 13'd1,   1'b0, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_COLS, 13'd1,   1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd255, 1'b1, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd0,   1'b1, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_ROWS, 13'd0,   1'b0, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_COLS, 13'd0,   1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'h05a, 1'b1, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_ROWS, 13'd2,   1'b0, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_COLS, 13'd2,   1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd0,   1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd255, 1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd255, 1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd0,   1'b1, 8'd255},
		'{D_CFG, mgrad_pkg::REG_FRAME_ROWS, 13'd3,   1'b0, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_COLS, 13'd1,   1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd10,  1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd20,  1'b1, 8'd10},
		'{D_CFG, REG_UNUSED,                13'd0,   1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'd30,  1'b0, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_ROWS, 13'h1fff, 1'b0, 8'd0},
		'{D_CFG, mgrad_pkg::REG_FRAME_COLS, 13'h07ff, 1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'h001, 1'b0, 8'd0},
		'{D_PIX, mgrad_pkg::REG_FRAME_ROWS, 13'h080, 1'b0, 8'd0}
	};

	logic          clk          = 1'b0;
	logic          arst_n       = 1'b0;
	logic          cfg_valid    = 1'b0;
	logic          cfg_ready;
	logic [IW-1:0] cfg_index    = '0;
	logic [DW-1:0] cfg_data     = '0;
	logic          in_valid     = 1'b0;
	logic          in_ready;
	logic [PW-1:0] pixel        = '0;
	logic          out_valid;
	logic          out_ready    = 1'b0;
	logic [PW-1:0] grad_value;
	logic [RW-1:0] out_row;
	logic [CW-1:0] out_col;
	logic          last_in_run;
	logic          end_of_frame;

	logic          px_typed     = 1'b0;
	logic [PW-1:0] px_tgrad     = '0;
	logic          hold_arm     = 1'b0;

	// predictor state
	logic [12:0]   rows_reg;
	logic [10:0]   cols_reg;
	logic [PW-1:0] line_old [NCOL];
	logic [PW-1:0] line_new [NCOL];
	logic [PW-1:0] win [9];
	int unsigned   cur_row;
	int unsigned   cur_col;

	mgrad_pkg::res_word_t due_words [$];
	int                   errors;
	int                   px_in;
	int                   words_out;
	int                   cfg_writes;
	int                   burst_left;
	int unsigned          cycles;

	morph_gradient_3x3 i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.grad_value  (grad_value),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_in_run (last_in_run),
		.end_of_frame(end_of_frame)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles, due_words.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic flag(input string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	// max minus min over the clipped window around column centre of the window
	function automatic logic [PW-1:0] clip_grad(input int centre, input bit left_ok,
		input logic [2:0] rows_ok);
		int lo;
		int hi;
		lo = 256;
		hi = 0;
		for (int k = 0; k < 3; k++) begin
			if (!rows_ok[k]) continue;
			for (int j = 0; j < 3; j++) begin
				if (j + 1 < centre) continue;
				if (j + 1 == centre && !left_ok) continue;
				if (j > centre + 1) continue;
				if (win[k*3+j] < lo) lo = win[k*3+j];
				if (win[k*3+j] > hi) hi = win[k*3+j];
			end
		end
		if (hi < lo) return '0;
		return PW'(hi - lo);
	endfunction

	function automatic mgrad_pkg::res_word_t grad_word(input int unsigned r,
		input int unsigned c, input int centre, input logic [2:0] rows_ok,
		input int unsigned nr, input int unsigned nc);
		mgrad_pkg::res_word_t w;
		w.grad = clip_grad(centre, c >= 1, rows_ok);
		w.row  = r[RW-1:0];
		w.col  = c[CW-1:0];
		w.last = 1'b0;
		w.eof  = (r == nr - 1) && (c == nc - 1);
		return w;
	endfunction

	task automatic push_gradients(input logic [PW-1:0] p, input logic typed,
		input logic [PW-1:0] tg);
		int unsigned          nr;
		int unsigned          nc;
		int unsigned          c;
		int unsigned          i;
		bit                   lastc;
		bit                   fin;
		logic [2:0]           ok_up;
		logic [2:0]           ok_fin;
		mgrad_pkg::res_word_t made [NRES];
		int                   nmade;
		nmade = 0;
		nr = (rows_reg == 0) ? 1 : (rows_reg > NROW) ? NROW : rows_reg;
		nc = (cols_reg == 0) ? 1 : (cols_reg > NCOL) ? NCOL : cols_reg;
		if (cur_col >= nc || cur_row >= nr) begin
			cur_col = 0;
			cur_row = 0;
		end
		c = cur_col;
		i = cur_row;
		for (int k = 0; k < 3; k++) begin
			win[k*3]   = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = line_old[c];
		win[5] = line_new[c];
		win[8] = p;
		line_old[c] = line_new[c];
		line_new[c] = p;
		lastc  = (c == nc - 1);
		fin    = (i == nr - 1);
		ok_up  = (i >= 2) ? 3'b111 : 3'b110;
		ok_fin = (i >= 1) ? 3'b110 : 3'b100;
		if (i >= 1) begin
			if (c >= 1) begin
				made[nmade] = grad_word(i - 1, c - 1, 1, ok_up, nr, nc);
				nmade++;
			end
			if (lastc) begin
				made[nmade] = grad_word(i - 1, c, 2, ok_up, nr, nc);
				nmade++;
			end
		end
		if (fin) begin
			if (c >= 1) begin
				made[nmade] = grad_word(i, c - 1, 1, ok_fin, nr, nc);
				nmade++;
			end
			if (lastc) begin
				made[nmade] = grad_word(i, c, 2, ok_fin, nr, nc);
				nmade++;
			end
		end
		if (nmade > 0) made[nmade-1].last = 1'b1;
		for (int m = 0; m < nmade; m++) begin
			if (typed) made[m].grad = tg;
			due_words = {due_words, made[m]};
		end
		if (lastc) begin
			cur_col = 0;
			cur_row = fin ? 0 : i + 1;
		end else begin
			cur_col = c + 1;
		end
	endtask

	initial begin
		rows_reg = 13'd480;
		cols_reg = 11'd640;
		cur_row  = 0;
		cur_col  = 0;
		foreach (win[k]) win[k] = '0;
		foreach (line_old[k]) begin
			line_old[k] = '0;
			line_new[k] = '0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			cfg_writes++;
			if (cfg_index == mgrad_pkg::REG_FRAME_ROWS ||
				cfg_index == mgrad_pkg::REG_FRAME_COLS) begin
				if (cfg_index == mgrad_pkg::REG_FRAME_ROWS) rows_reg = cfg_data;
				else cols_reg = cfg_data[10:0];
				cur_row = 0;
				cur_col = 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			px_in++;
			push_gradients(pixel, px_typed, px_tgrad);
		end
	end

	always @(posedge clk) begin : out_check
		mgrad_pkg::res_word_t got;
		mgrad_pkg::res_word_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {grad_value, out_row, out_col, last_in_run, end_of_frame};
			words_out++;
			if (due_words.size() == 0) begin
				flag($sformatf("unexpected word row %0d col %0d grad %0d",
					got.row, got.col, got.grad));
			end else begin
				want = due_words.pop_front();
				if (got.grad !== want.grad || got.row !== want.row || got.col !== want.col ||
					got.last !== want.last || got.eof !== want.eof)
					flag($sformatf("got r%0d c%0d g%0d l%b e%b, want r%0d c%0d g%0d l%b e%b",
						got.row, got.col, got.grad, got.last, got.eof,
						want.row, want.col, want.grad, want.last, want.eof));
			end
		end
	end

	// receiver: changing stall patterns, plus one long hold-off
	initial begin : rx_pattern
		rx_mode_t mode;
		int       span;
		int       tick;
		bit       held;
		mode = RX_OPEN;
		span = 0;
		tick = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_arm && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(32, 256);
			end
			span--;
			tick++;
			case (mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_SPARSE: out_ready <= (tick % 4 == 0);
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				default:   out_ready <= (tick % 4 != 0);
			endcase
		end
	end

	task automatic send_pixel(input logic [PW-1:0] p, input logic typed,
		input logic [PW-1:0] tg);
		in_valid <= 1'b1;
		pixel    <= p;
		px_typed <= typed;
		px_tgrad <= tg;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 16);
		end
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every due word is out and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int            nr;
		int            nc;
		int            frames;
		int            cut;
		int            total;
		int            rand_px;
		px_style_t     style;
		logic [PW-1:0] p;
		errors     = 0;
		px_in      = 0;
		words_out  = 0;
		cfg_writes = 0;
		burst_left = 0;
		cycles     = 0;
		rand_px    = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[s]) begin
			if (DIRECTED[s].kind == D_CFG) begin
				settle();
				write_reg(DIRECTED[s].idx, DIRECTED[s].val);
			end else begin
				send_pixel(DIRECTED[s].val[PW-1:0], DIRECTED[s].typed, DIRECTED[s].tgrad);
			end
		end

		// small frames, mostly whole, some cut short
		while (rand_px < RAND_PIXELS) begin
			nr = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
			nc = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			frames = $urandom_range(1, 2);
			cut = (nr * nc > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, nr * nc - 1) : 0;
			total = (cut != 0) ? (frames - 1) * nr * nc + cut : frames * nr * nc;
			if (total > RAND_PIXELS - rand_px) total = RAND_PIXELS - rand_px;
			style = px_style_t'($urandom_range(0, 2));
			settle();
			write_reg(mgrad_pkg::REG_FRAME_ROWS, DW'(nr));
			write_reg(mgrad_pkg::REG_FRAME_COLS, DW'(nc));
			for (int k = 0; k < total; k++) begin
				case (style)
					PX_ANY:  p = PW'($urandom_range(0, 255));
					PX_FLAT: p = PW'(100 + $urandom_range(0, 7));
					default: p = $urandom_range(0, 1) ? 8'hff : 8'h00;
				endcase
				send_pixel(p, 1'b0, '0);
			end
			rand_px += total;
		end

		// tall single column, with the receiver held off for a while
		settle();
		write_reg(mgrad_pkg::REG_FRAME_ROWS, DW'(TALL_ROWS));
		write_reg(mgrad_pkg::REG_FRAME_COLS, 13'd1);
		hold_arm <= 1'b1;
		for (int k = 0; k < TALL_ROWS; k++) send_pixel(PW'($urandom_range(0, 255)), 1'b0, '0);

		settle();
		$display("run: %0d pixels in, %0d gradient words checked, %0d register writes",
			px_in, words_out, cfg_writes);
		$display("tiny and clamped frame sizes, an unused register index, bursty input and a full queue");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
